[sv/glyph_text_layout_macros.svh]
// ----------------------------------------------------------------------------
// glyph_text_layout assertion macros
// Clocked assertion wrappers for the text layout block; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_LAYOUT_MACROS_SVH
`define GLYPH_TEXT_LAYOUT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clk edge outside reset
`define GTL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen on a rising clk edge outside reset
`define GTL_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define GTL_ASSERT(label, prop, msg)
`define GTL_ASSERT_NEVER(label, expr, msg)

`endif

`endif

[sv/gtl_pkg.sv]
// ----------------------------------------------------------------------------
// gtl_pkg
// Shared widths, codes and types of the glyph text layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtl_pkg;

	localparam int GLYPH_CODES_DEF = 256;

	localparam int CODE_W     = 16;
	localparam int ATLAS_W    = 12;
	localparam int DIM_W      = 10;
	localparam int ORIGIN_W   = 16;
	localparam int SCALE_W    = 16;
	localparam int TEXSZ_W    = 13;
	localparam int POS_W      = 32;
	localparam int SIZE_W     = 26;
	localparam int TC_W       = 17;
	localparam int COLOR_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SUBPX_W    = 8;
	localparam int PROD_W     = DIM_W + SCALE_W + 1;
	localparam int SUM_W      = POS_W + 2;
	localparam int FRAC_W     = 16;
	localparam int DIV_BITS   = 2;
	localparam int DIV_STEPS  = FRAC_W / DIV_BITS;

	localparam logic [CODE_W-1:0]  NEWLINE_CODE = 16'd10;
	localparam logic [TC_W-1:0]    TC_ONE       = 17'h10000;
	localparam logic [SCALE_W-1:0] SCALE_ONE    = 16'd256;

	// request actions
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;
	localparam logic [1:0] ACT_CHAR  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_ENABLE  = 3'd4;

	// texture coordinate slots, also the divider job order
	localparam logic [1:0] DIV_TEX_U  = 2'd0;
	localparam logic [1:0] DIV_TEX_V  = 2'd1;
	localparam logic [1:0] DIV_SPAN_U = 2'd2;
	localparam logic [1:0] DIV_SPAN_V = 2'd3;

	typedef enum logic [2:0] {
		MUL_LH,
		MUL_GW,
		MUL_GH,
		MUL_OX,
		MUL_OY,
		MUL_ADV
	} gtl_mul_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_NL,
		ACC_SX,
		ACC_SY,
		ACC_CX,
		ACC_CY,
		ACC_PX
	} gtl_acc_t;

	typedef struct packed {
		logic [1:0]                 action;
		logic [CODE_W-1:0]          code_point;
		logic [ATLAS_W-1:0]         atlas_x;
		logic [ATLAS_W-1:0]         atlas_y;
		logic [DIM_W-1:0]           glyph_width;
		logic [DIM_W-1:0]           glyph_height;
		logic signed [DIM_W-1:0]    offset_x;
		logic signed [DIM_W-1:0]    offset_y;
		logic [DIM_W-1:0]           advance;
		logic signed [ORIGIN_W-1:0] origin_x;
		logic signed [ORIGIN_W-1:0] origin_y;
		logic [SCALE_W-1:0]         scale;
	} gtl_item_t;

	typedef struct packed {
		logic                    valid;
		logic [ATLAS_W-1:0]      atlas_y;
		logic [ATLAS_W-1:0]      atlas_x;
		logic [DIM_W-1:0]        advance;
		logic signed [DIM_W-1:0] offset_y;
		logic signed [DIM_W-1:0] offset_x;
		logic [DIM_W-1:0]        glyph_height;
		logic [DIM_W-1:0]        glyph_width;
	} gtl_glyph_t;

	typedef struct packed {
		logic signed [POS_W-1:0] center_x;
		logic signed [POS_W-1:0] center_y;
		logic [SIZE_W-1:0]       size_x;
		logic [SIZE_W-1:0]       size_y;
		logic [TC_W-1:0]         tex_u;
		logic [TC_W-1:0]         tex_v;
		logic [TC_W-1:0]         tex_span_u;
		logic [TC_W-1:0]         tex_span_v;
		logic [COLOR_W-1:0]      sprite_color;
	} gtl_result_t;

	typedef struct packed {
		logic     capture;
		logic     clr_we;
		logic     load_we;
		logic     start_set;
		gtl_mul_t mul_sel;
		gtl_acc_t acc_op;
		logic     div_start;
		logic [1:0] div_sel;
	} gtl_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       tex_en;
		logic       newline;
		logic       hit;
		logic       clr_last;
		logic       div_done;
	} gtl_status_t;

	// clamp a widened sum to the signed 32-bit range
	function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		if ((&v[SUM_W-1:POS_W-1]) || !(|v[SUM_W-1:POS_W-1]))
			return v[POS_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return {1'b0, {(POS_W-1){1'b1}}};
	endfunction

endpackage

`default_nettype wire

[sv/glyph_text_layout.sv]
// ----------------------------------------------------------------------------
// glyph_text_layout
// Bitmap-font text layout engine producing one sprite command per drawn glyph.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low; busy stays
// high until the block can take the next one. A result appears for exactly
// one cycle with done high and cannot be held off, so the receiver must take
// it in that cycle. After reset, and after every clear request, the block
// sweeps all GLYPH_CODES entries of the glyph memory, one entry per cycle,
// with busy high; configuration writes are still taken then. Load and start
// requests, characters that draw nothing and characters with no texture bound
// go back to idle straight from decode; a newline first takes a multiply and
// an add step. A drawn glyph passes through the shared multiplier walking
// size, offset and advance, then through one iterative divider working out
// the four texture coordinates in turn at two quotient bits per cycle. A new
// request may be accepted in the done cycle itself.
`default_nettype none

`include "glyph_text_layout_macros.svh"

module glyph_text_layout
	import gtl_pkg::*;
#(
	parameter int GLYPH_CODES = GLYPH_CODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,

	// request channel
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [CODE_W-1:0]          code_point,
	input  logic [ATLAS_W-1:0]         atlas_x,
	input  logic [ATLAS_W-1:0]         atlas_y,
	input  logic [DIM_W-1:0]           glyph_width,
	input  logic [DIM_W-1:0]           glyph_height,
	input  logic signed [DIM_W-1:0]    offset_x,
	input  logic signed [DIM_W-1:0]    offset_y,
	input  logic [DIM_W-1:0]           advance,
	input  logic signed [ORIGIN_W-1:0] origin_x,
	input  logic signed [ORIGIN_W-1:0] origin_y,
	input  logic [SCALE_W-1:0]         scale,

	// configuration write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,

	// sprite command, one cycle per done strobe
	output logic                       done,
	output logic signed [POS_W-1:0]    center_x,
	output logic signed [POS_W-1:0]    center_y,
	output logic [SIZE_W-1:0]          size_x,
	output logic [SIZE_W-1:0]          size_y,
	output logic [TC_W-1:0]            tex_u,
	output logic [TC_W-1:0]            tex_v,
	output logic [TC_W-1:0]            tex_span_u,
	output logic [TC_W-1:0]            tex_span_v,
	output logic [COLOR_W-1:0]         sprite_color
);

	gtl_item_t   item;
	gtl_cmd_t    cmd;
	gtl_status_t status;
	gtl_result_t result;

	// the user must write registers only while idle; the block does not enforce it, so writes are always taken
	assign cfg_ready = 1'b1;

	// request payload bundled for capture in the datapath
	always_comb begin
		item.action       = action;
		item.code_point   = code_point;
		item.atlas_x      = atlas_x;
		item.atlas_y      = atlas_y;
		item.glyph_width  = glyph_width;
		item.glyph_height = glyph_height;
		item.offset_x     = offset_x;
		item.offset_y     = offset_y;
		item.advance      = advance;
		item.origin_x     = origin_x;
		item.origin_y     = origin_y;
		item.scale        = scale;
	end

	// sequencer: clear sweep, decode, multiply steps, divider jobs
	gtl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// glyph memory, pen state, multiplier, clamp adder and divider
	gtl_dp #(
		.GLYPH_CODES (GLYPH_CODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// result fields straight from the datapath output registers
	assign center_x     = result.center_x;
	assign center_y     = result.center_y;
	assign size_x       = result.size_x;
	assign size_y       = result.size_y;
	assign tex_u        = result.tex_u;
	assign tex_v        = result.tex_v;
	assign tex_span_u   = result.tex_span_u;
	assign tex_span_v   = result.tex_span_v;
	assign sprite_color = result.sprite_color;

	// an accepted request always leaves the sequencer busy on the next cycle
	`GTL_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request left block idle")
	// the result strobe is a single-cycle pulse that follows busy work
	`GTL_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
	`GTL_ASSERT(a_done_after_work, done |-> $past(busy), "result strobe without prior work")
	// glyph memory writes only come from a load request or the clear sweep
	`GTL_ASSERT(a_load_action, cmd.load_we |-> (status.action == ACT_LOAD),
		"glyph write outside a load request")
	`GTL_ASSERT_NEVER(a_clear_capture, cmd.clr_we && cmd.capture,
		"request captured during the clear sweep")

endmodule

`default_nettype wire

[sv/gtl_div.sv]
// ----------------------------------------------------------------------------
// gtl_div
// Iterative 1.16 fraction divider, two quotient bits per cycle, clamped at 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module gtl_div
	import gtl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ATLAS_W-1:0] num,
	input  logic [TEXSZ_W-1:0] den,
	output logic               done,
	output logic [TC_W-1:0]    quo
);

	localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic [TEXSZ_W:0]   rem_q, rem_d;
	logic [FRAC_W-1:0]  quo_q, quo_d;
	logic [TEXSZ_W-1:0] den_q;
	logic               sat_q;
	logic               run_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;

	// restoring steps; remainder stays below the divisor unless clamped
	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			rem_d = {rem_d[TEXSZ_W-1:0], 1'b0};
			if (rem_d >= {1'b0, den_q}) begin
				rem_d = rem_d - {1'b0, den_q};
				quo_d = {quo_d[FRAC_W-2:0], 1'b1};
			end else begin
				quo_d = {quo_d[FRAC_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_LAST);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST)
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(TEXSZ_W+1-ATLAS_W){1'b0}}, num};
			quo_q <= '0;
			den_q <= den;
			// num >= den means a quotient of 1.0 or more, zero divisor included
			sat_q <= ({1'b0, num} >= den);
		end else if (run_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign done = done_q;
	assign quo  = sat_q ? TC_ONE : {1'b0, quo_q};

endmodule

`default_nettype wire

[sv/gtl_dp.sv]
// ----------------------------------------------------------------------------
// gtl_dp
// Datapath: config registers, glyph memory, pen state, shared multiplier,
// saturating adder and the texture coordinate divider.
// ----------------------------------------------------------------------------
`default_nettype none

module gtl_dp
	import gtl_pkg::*;
#(
	parameter int GLYPH_CODES = GLYPH_CODES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  gtl_item_t             item,
	input  gtl_cmd_t              cmd,
	output gtl_status_t           status,
	output gtl_result_t           result
);

	localparam int AW = (GLYPH_CODES > 1) ? $clog2(GLYPH_CODES) : 1;
	localparam logic [CODE_W:0] CODE_LIMIT = (CODE_W+1)'(GLYPH_CODES);
	localparam logic [AW-1:0]   LAST_ADDR  = AW'(GLYPH_CODES - 1);
	localparam int PEN_EXT = POS_W - ORIGIN_W - SUBPX_W;

	// configuration
	logic [DIM_W-1:0]   line_height_q;
	logic [TEXSZ_W-1:0] tex_w_q;
	logic [TEXSZ_W-1:0] tex_h_q;
	logic [COLOR_W-1:0] color_q;
	logic               tex_en_q;

	// item and glyph memory
	gtl_item_t  item_q;
	gtl_glyph_t mem [GLYPH_CODES];
	gtl_glyph_t rd_q;
	gtl_glyph_t wr_data;
	logic [AW-1:0] wr_addr;
	logic          mem_we;
	logic [AW-1:0] clr_addr_q;
	logic          in_range;

	// pen state
	logic signed [POS_W-1:0] pen_x_q;
	logic signed [POS_W-1:0] pen_y_q;
	logic signed [POS_W-1:0] line_start_q;
	logic [SCALE_W-1:0]      scale_q;

	// arithmetic
	logic signed [DIM_W:0]    mul_a;
	logic signed [SCALE_W:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [POS_W-1:0]  acc_base;
	logic [SIZE_W-2:0]        acc_half;
	logic signed [SUM_W-1:0]  acc_sum;
	logic signed [POS_W-1:0]  acc_sat;

	// outputs
	logic signed [POS_W-1:0] center_x_q;
	logic signed [POS_W-1:0] center_y_q;
	logic [SIZE_W-1:0]       size_x_q;
	logic [SIZE_W-1:0]       size_y_q;
	logic [TC_W-1:0]         tex_q [4];

	// divider
	logic [ATLAS_W-1:0] div_num;
	logic [TEXSZ_W-1:0] div_den;
	logic               div_done;
	logic [TC_W-1:0]    div_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_height_q <= '0;
			tex_w_q       <= TEXSZ_W'(256);
			tex_h_q       <= TEXSZ_W'(256);
			color_q       <= '1;
			tex_en_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINE_HEIGHT: line_height_q <= cfg_data[DIM_W-1:0];
				CFG_TEX_WIDTH:   tex_w_q       <= cfg_data[TEXSZ_W-1:0];
				CFG_TEX_HEIGHT:  tex_h_q       <= cfg_data[TEXSZ_W-1:0];
				CFG_DRAW_COLOR:  color_q       <= cfg_data[COLOR_W-1:0];
				CFG_TEX_ENABLE:  tex_en_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= item;
	end

	assign in_range = {1'b0, item_q.code_point} < CODE_LIMIT;

	// one write port shared by the clear sweep and glyph loads
	always_comb begin
		wr_data = '0;
		if (!cmd.clr_we) begin
			wr_data.valid        = 1'b1;
			wr_data.atlas_x      = item_q.atlas_x;
			wr_data.atlas_y      = item_q.atlas_y;
			wr_data.glyph_width  = item_q.glyph_width;
			wr_data.glyph_height = item_q.glyph_height;
			wr_data.offset_x     = item_q.offset_x;
			wr_data.offset_y     = item_q.offset_y;
			wr_data.advance      = item_q.advance;
		end
	end

	assign wr_addr = cmd.clr_we ? clr_addr_q : item_q.code_point[AW-1:0];
	assign mem_we  = cmd.clr_we || (cmd.load_we && in_range);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		if (cmd.capture)
			rd_q <= mem[item.code_point[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clr_we)
			clr_addr_q <= (clr_addr_q == LAST_ADDR) ? '0 : clr_addr_q + 1'b1;
	end

	// shared 11x17 signed multiplier, product registered
	always_comb begin
		unique case (cmd.mul_sel)
			MUL_LH:  mul_a = {1'b0, line_height_q};
			MUL_GW:  mul_a = {1'b0, rd_q.glyph_width};
			MUL_GH:  mul_a = {1'b0, rd_q.glyph_height};
			MUL_OX:  mul_a = {rd_q.offset_x[DIM_W-1], rd_q.offset_x};
			MUL_OY:  mul_a = {rd_q.offset_y[DIM_W-1], rd_q.offset_y};
			MUL_ADV: mul_a = {1'b0, rd_q.advance};
			default: mul_a = '0;
		endcase
	end

	assign mul_b = {1'b0, scale_q};

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a * mul_b);
	end

	// pen plus product plus half size, clamped
	always_comb begin
		unique case (cmd.acc_op)
			ACC_NL: begin
				acc_base = pen_y_q;
				acc_half = '0;
			end
			ACC_CX: begin
				acc_base = pen_x_q;
				acc_half = size_x_q[SIZE_W-1:1];
			end
			ACC_CY: begin
				acc_base = pen_y_q;
				acc_half = size_y_q[SIZE_W-1:1];
			end
			default: begin
				acc_base = pen_x_q;
				acc_half = '0;
			end
		endcase
		acc_sum = SUM_W'(acc_base) + SUM_W'(prod_q) + SUM_W'($signed({1'b0, acc_half}));
	end

	assign acc_sat = sat32(acc_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q      <= '0;
			pen_y_q      <= '0;
			line_start_q <= '0;
			scale_q      <= SCALE_ONE;
		end else if (cmd.start_set) begin
			pen_x_q      <= {{PEN_EXT{item_q.origin_x[ORIGIN_W-1]}}, item_q.origin_x,
				{SUBPX_W{1'b0}}};
			line_start_q <= {{PEN_EXT{item_q.origin_x[ORIGIN_W-1]}}, item_q.origin_x,
				{SUBPX_W{1'b0}}};
			pen_y_q      <= {{PEN_EXT{item_q.origin_y[ORIGIN_W-1]}}, item_q.origin_y,
				{SUBPX_W{1'b0}}};
			scale_q      <= item_q.scale;
		end else if (cmd.acc_op == ACC_NL) begin
			pen_x_q <= line_start_q;
			pen_y_q <= acc_sat;
		end else if (cmd.acc_op == ACC_PX) begin
			pen_x_q <= acc_sat;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.acc_op)
			ACC_SX:  size_x_q   <= prod_q[SIZE_W-1:0];
			ACC_SY:  size_y_q   <= prod_q[SIZE_W-1:0];
			ACC_CX:  center_x_q <= acc_sat;
			ACC_CY:  center_y_q <= acc_sat;
			default: ;
		endcase
		if (div_done)
			tex_q[cmd.div_sel] <= div_quo;
	end

	always_comb begin
		unique case (cmd.div_sel)
			DIV_TEX_U: begin
				div_num = rd_q.atlas_x;
				div_den = tex_w_q;
			end
			DIV_TEX_V: begin
				div_num = rd_q.atlas_y;
				div_den = tex_h_q;
			end
			DIV_SPAN_U: begin
				div_num = {{(ATLAS_W-DIM_W){1'b0}}, rd_q.glyph_width};
				div_den = tex_w_q;
			end
			DIV_SPAN_V: begin
				div_num = {{(ATLAS_W-DIM_W){1'b0}}, rd_q.glyph_height};
				div_den = tex_h_q;
			end
		endcase
	end

	gtl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		status.action   = item_q.action;
		status.tex_en   = tex_en_q;
		status.newline  = (item_q.code_point == NEWLINE_CODE);
		status.hit      = in_range && rd_q.valid;
		status.clr_last = (clr_addr_q == LAST_ADDR);
		status.div_done = div_done;
	end

	always_comb begin
		result.center_x     = center_x_q;
		result.center_y     = center_y_q;
		result.size_x       = size_x_q;
		result.size_y       = size_y_q;
		result.tex_u        = tex_q[DIV_TEX_U];
		result.tex_v        = tex_q[DIV_TEX_V];
		result.tex_span_u   = tex_q[DIV_SPAN_U];
		result.tex_span_v   = tex_q[DIV_SPAN_V];
		result.sprite_color = color_q;
	end

endmodule

`default_nettype wire

[sv/gtl_ctrl.sv]
// ----------------------------------------------------------------------------
// gtl_ctrl
// Sequencer: clear sweep, request decode, multiply steps and divider jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module gtl_ctrl
	import gtl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  gtl_status_t status,
	output logic        busy,
	output logic        done,
	output gtl_cmd_t    cmd
);

	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_DECODE   = 4'd2;
	localparam logic [3:0] S_NL_MUL   = 4'd3;
	localparam logic [3:0] S_NL_ADD   = 4'd4;
	localparam logic [3:0] S_G_GW     = 4'd5;
	localparam logic [3:0] S_G_GH     = 4'd6;
	localparam logic [3:0] S_G_OX     = 4'd7;
	localparam logic [3:0] S_G_OY     = 4'd8;
	localparam logic [3:0] S_G_ADV    = 4'd9;
	localparam logic [3:0] S_G_PEN    = 4'd10;
	localparam logic [3:0] S_DIV_GO   = 4'd11;
	localparam logic [3:0] S_DIV_WAIT = 4'd12;

	logic [3:0] state_q, state_d;
	logic [1:0] dsel_q;
	logic       done_q;
	logic       last_div;

	assign last_div = (state_q == S_DIV_WAIT) && status.div_done && (dsel_q == DIV_SPAN_V);

	always_comb begin
		state_d       = state_q;
		cmd.capture   = 1'b0;
		cmd.clr_we    = 1'b0;
		cmd.load_we   = 1'b0;
		cmd.start_set = 1'b0;
		cmd.mul_sel   = MUL_LH;
		cmd.acc_op    = ACC_NONE;
		cmd.div_start = 1'b0;
		cmd.div_sel   = dsel_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (status.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.action)
					ACT_CLEAR: state_d = S_CLEAR;
					ACT_LOAD: begin
						cmd.load_we = 1'b1;
						state_d     = S_IDLE;
					end
					ACT_START: begin
						cmd.start_set = 1'b1;
						state_d       = S_IDLE;
					end
					ACT_CHAR: begin
						priority if (!status.tex_en)
							state_d = S_IDLE;
						else if (status.newline)
							state_d = S_NL_MUL;
						else if (status.hit)
							state_d = S_G_GW;
						else
							state_d = S_IDLE;
					end
				endcase
			end
			S_NL_MUL: begin
				cmd.mul_sel = MUL_LH;
				state_d     = S_NL_ADD;
			end
			S_NL_ADD: begin
				cmd.acc_op = ACC_NL;
				state_d    = S_IDLE;
			end
			S_G_GW: begin
				cmd.mul_sel = MUL_GW;
				state_d     = S_G_GH;
			end
			S_G_GH: begin
				cmd.mul_sel = MUL_GH;
				cmd.acc_op  = ACC_SX;
				state_d     = S_G_OX;
			end
			S_G_OX: begin
				cmd.mul_sel = MUL_OX;
				cmd.acc_op  = ACC_SY;
				state_d     = S_G_OY;
			end
			S_G_OY: begin
				cmd.mul_sel = MUL_OY;
				cmd.acc_op  = ACC_CX;
				state_d     = S_G_ADV;
			end
			S_G_ADV: begin
				cmd.mul_sel = MUL_ADV;
				cmd.acc_op  = ACC_CY;
				state_d     = S_G_PEN;
			end
			S_G_PEN: begin
				cmd.acc_op = ACC_PX;
				state_d    = S_DIV_GO;
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (status.div_done)
					state_d = (dsel_q == DIV_SPAN_V) ? S_IDLE : S_DIV_GO;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			dsel_q  <= DIV_TEX_U;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= last_div;
			if (state_q == S_G_PEN)
				dsel_q <= DIV_TEX_U;
			else if ((state_q == S_DIV_WAIT) && status.div_done && !last_div)
				dsel_q <= dsel_q + 1'b1;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire
